// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W       = 32;
  localparam int PRIO_W       = 16;
  localparam int COUNT_W      = 4;
  localparam int CAPACITY_DEF = 8;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_kind_t;

  // one stored entry of the sorted chain
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ===== rtl/core/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] data_in;
  logic signed [PRIO_W-1:0] prio_in;

  modport source (output valid, output kind, output data_in, output prio_in, input ready);
  modport sink   (input valid, input kind, input data_in, input prio_in, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data_out;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output data_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input data_out, input entry_count,
                  output ready);
endinterface

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Shift-register priority queue: entries sorted by ascending signed priority.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | transaction
//  ---------+-----+--------------------------------------+------------------------
//  in_ch    | in  | kind, data_in, prio_in               | valid & ready
//  out_ch   | out | status, data_out, entry_count        | valid & ready
//
//  - one command per cycle unless stalled: every cell decides its next content
//    in the same cycle from its entry and neighbours, so the chain is updated
//    on the edge that accepts the command and the result appears next cycle
//  - the result sits in an output register; a new command is taken whenever
//    that register is empty or being drained in the same cycle
//  - a stalled result is held unchanged and blocks further commands
//  - synchronous active-low reset empties the chain (valid bits and count);
//    stored words and priorities are not reset
//
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // chain wiring
  entry_t    cell_entry [CAPACITY];
  logic      cell_le    [CAPACITY];
  entry_t    left_entry [CAPACITY];
  logic      left_le    [CAPACITY];
  entry_t    right_entry[CAPACITY];
  cell_ctl_t ctl;

  // occupancy and output register
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [DATA_W-1:0]  data_out_r, data_out_nxt;
  logic [CNT_W-1:0]   count_out_r;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic accept;
  logic is_full;
  logic is_empty;

  // a new command may enter while the held result leaves
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // head and tail valid bits give empty and full directly
  assign is_empty = !cell_entry[0].valid;
  assign is_full  = cell_entry[CAPACITY-1].valid;

  assign ctl.enq = accept && (in_ch.kind == OP_ENQ) && !is_full;
  assign ctl.deq = accept && (in_ch.kind == OP_DEQ) && !is_empty;

  // neighbour links; the head sees an open slot on its left,
  // the tail pulls in an empty entry on a dequeue
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        left_entry[i] = '0;
        left_le[i]    = 1'b1;
      end else begin
        left_entry[i] = cell_entry[i-1];
        left_le[i]    = cell_le[i-1];
      end
      if (i == CAPACITY - 1) begin
        right_entry[i] = '0;
      end else begin
        right_entry[i] = cell_entry[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_data    (in_ch.data_in),
      .new_prio    (in_ch.prio_in),
      .left_entry  (left_entry[g]),
      .left_le     (left_le[g]),
      .right_entry (right_entry[g]),
      .entry       (cell_entry[g]),
      .le          (cell_le[g])
    );
  end

  // status, dequeued word and next occupancy
  always_comb begin
    status_nxt   = ST_OK;
    data_out_nxt = '0;
    occ_nxt      = occ_r;
    case (in_ch.kind)
      OP_ENQ: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          occ_nxt = occ_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_out_nxt = cell_entry[0].data;
          occ_nxt      = occ_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      status_r    <= status_nxt;
      data_out_r  <= data_out_nxt;
      count_out_r <= occ_nxt;
    end
  end

  // count reported masked to the field width
  assign count_ext = {{COUNT_W{1'b0}}, count_out_r};

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.data_out    = data_out_r;
  assign out_ch.entry_count = count_ext[COUNT_W-1:0];

endmodule

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new item, or shifts.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] new_data,
  input  logic [PRIO_W-1:0] new_prio,
  input  entry_t            left_entry,
  input  logic              left_le,
  input  entry_t            right_entry,
  output entry_t            entry,
  output logic              le
);

  entry_t entry_r, entry_nxt;

  // entry stays ahead of the new item (fifo among equal priorities)
  assign le = entry_r.valid && ($signed(entry_r.prio) <= $signed(new_prio));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.enq) begin
      if (!le) begin
        if (left_le) begin
          entry_nxt.valid = 1'b1;
          entry_nxt.data  = new_data;
          entry_nxt.prio  = new_prio;
        end else begin
          entry_nxt = left_entry;
        end
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.data <= entry_nxt.data;
    entry_r.prio <= entry_nxt.prio;
  end

  assign entry = entry_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue unit: drives enqueue and
// dequeue transactions with random gaps and back-pressure, predicts every
// result from a sorted model of the queue and compares status, data and count.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;
  localparam int RANDOM_PER_PHASE = 517;
  localparam int CYCLE_LIMIT = 400000;

  // one result as the queue should present it
  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } queue_reply_t;

  // one stored entry of the model queue
  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic signed [PRIO_W-1:0] prio;
  } queued_item_t;

  // sorted model of the queue plus the replies still owed by the block
  class spq_scoreboard;
    queued_item_t model_slots[$];
    queue_reply_t owed_replies[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    // apply one command to the model and work out the reply it causes
    function queue_reply_t apply_queue_op(op_kind_t op, logic signed [DATA_W-1:0] d,
                                          logic signed [PRIO_W-1:0] p);
      queue_reply_t rep;
      queued_item_t itm;
      int           pos;
      rep.status = ST_OK;
      rep.data   = '0;
      if (op == OP_ENQ) begin
        if (model_slots.size() >= QUEUE_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          // behind every entry of lower or equal priority
          pos = model_slots.size();
          while (pos > 0 && p < model_slots[pos-1].prio) pos--;
          itm.data = d;
          itm.prio = p;
          model_slots.insert(pos, itm);
        end
      end else begin
        if (model_slots.size() == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          itm = model_slots.pop_front();
          rep.data = itm.data;
        end
      end
      rep.count = COUNT_W'(model_slots.size());
      return rep;
    endfunction

    function void note_command(op_kind_t op, logic signed [DATA_W-1:0] d,
                               logic signed [PRIO_W-1:0] p);
      owed_replies.push_back(apply_queue_op(op, d, p));
    endfunction

    task check_result(logic [1:0] st, logic signed [DATA_W-1:0] d, logic [COUNT_W-1:0] c);
      queue_reply_t exp;
      if (owed_replies.size() == 0) begin
        report($sformatf("result st=%0d data=%h count=%0d with nothing owed", st, d, c));
      end else begin
        exp = owed_replies.pop_front();
        if (st !== exp.status)
          report($sformatf("status %0d, wanted %0d", st, exp.status));
        if (d !== exp.data)
          report($sformatf("data_out %h, wanted %h", d, exp.data));
        if (c !== exp.count)
          report($sformatf("entry_count %0d, wanted %0d", c, exp.count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  spq_scoreboard sb = new();

  // idle rates in percent, changed per phase
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned cycle_count;

  sorted_priority_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = OP_ENQ;
    in_ch.data_in = '0;
    in_ch.prio_in = '0;
    out_ch.ready  = 1'b0;
    src_idle_pct  = 19;
    sink_idle_pct = 59;
  end

  // receiver back-pressure, changed only on the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // result monitor: sampled on the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.data_out, out_ch.entry_count);
  end

  // watchdog: ends a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // offer one command; starts and ends on a falling edge, valid left high
  task automatic send_command(op_kind_t op, logic signed [DATA_W-1:0] d,
                              logic signed [PRIO_W-1:0] p);
    // random gap before the transaction
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= op;
    in_ch.data_in <= d;
    in_ch.prio_in <= p;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(op, d, p);
    @(negedge clk);
  endtask

  // sender holds off until every owed reply has been seen
  task automatic drain_pause();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  initial begin
    int                       ph;
    int                       n;
    int                       seg;
    int                       j;
    int unsigned              enq_bias;
    int unsigned              bias_pool[5];
    op_kind_t                 op;
    logic signed [DATA_W-1:0] d;
    logic signed [PRIO_W-1:0] p;

    bias_pool = '{10, 35, 50, 70, 92};

    // synchronous reset held low, then released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part: empty dequeue, extremes, ties, full reject, drain
    send_command(OP_DEQ, 32'sh1234_5678, 16'sh7fff);
    send_command(OP_ENQ, 32'sh7fff_ffff, 16'sh7fff);
    send_command(OP_ENQ, 32'sh8000_0000, 16'sh8000);
    send_command(OP_ENQ, 32'sh0000_0000, 16'sh0000);
    // equal priorities must leave in arrival order
    send_command(OP_ENQ, 32'shffff_ffff, 16'sh0000);
    send_command(OP_ENQ, 32'sh0000_0001, 16'sh0000);
    send_command(OP_ENQ, 32'sh5555_5555, 16'shffff);
    send_command(OP_ENQ, 32'shaaaa_aaaa, 16'sh7fff);
    send_command(OP_ENQ, 32'sh0000_007b, 16'sh8000);
    // queue full now: rejected, queue unchanged
    send_command(OP_ENQ, 32'shffff_ffff, 16'sh8000);
    repeat (QUEUE_DEPTH) send_command(OP_DEQ, 32'shffff_ffff, 16'shffff);
    // underflow twice
    send_command(OP_DEQ, 32'sh0000_0000, 16'sh0000);
    send_command(OP_DEQ, 32'shffff_ffff, 16'sh8000);
    drain_pause();

    // random part in three idling phases
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 19;
          sink_idle_pct = 59;
        end
        1: begin
          src_idle_pct  = 59;
          sink_idle_pct = 19;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        // segments with a fill or drain bias push the queue to full and empty
        enq_bias = bias_pool[$urandom_range(4)];
        seg      = $urandom_range(60, 20);
        for (j = 0; j < seg && n < RANDOM_PER_PHASE; j++) begin
          op = ($urandom_range(99) < enq_bias) ? OP_ENQ : OP_DEQ;
          d  = $urandom;
          case ($urandom_range(3))
            0: p = PRIO_W'($urandom_range(3) - 1);        // dense ties near zero
            1: begin
              case ($urandom_range(3))
                0: p = 16'sh8000;
                1: p = 16'sh7fff;
                2: p = 16'shffff;
                default: p = 16'sh0000;
              endcase
            end
            default: p = PRIO_W'($urandom);
          endcase
          send_command(op, d, p);
          n++;
          // mid-phase hold-off until the queue has caught up
          if (n == RANDOM_PER_PHASE / 2) drain_pause();
        end
      end
      drain_pause();
    end

    // all offered: wait for owed replies, then a short tail
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
